>>> design/sbb_pkg.sv
// shared types and constants for the separable box blur
// no dependencies
package sbb_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int DEF_MAX_RADIUS = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUR_RADIUS  = 2'd2;

    localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [11:0] RST_IMAGE_HEIGHT = 12'd480;
    localparam logic [3:0]  RST_BLUR_RADIUS  = 4'd1;

    typedef struct packed {
        logic       frame_start;
        logic [7:0] in_alpha;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } in_word_t;

    typedef struct packed {
        logic [10:0] out_col;
        logic [10:0] out_row;
        logic [7:0]  out_alpha;
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
        logic        frame_end;
    } out_word_t;

endpackage

>>> design/sbb_div.sv
// iterative restoring divider, one quotient bit per cycle
// no dependencies
module sbb_div #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quo,
    output logic [DEN_W-1:0] rem
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   trial;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= DEN_W'(trial - {1'b0, den_reg});
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[DEN_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

>>> design/sbb_line_mem.sv
// line store of horizontal averages, one write and one registered read port
// no dependencies
module sbb_line_mem #(
    parameter int DEPTH = 34816,
    parameter int AW    = 16,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/separable_box_blur.sv
// separable box blur top level: window, sequencer, dividers and line store
// depends on sbb_pkg, sbb_div, sbb_line_mem
//
//  channel  | valid      | stall      | word
//  pixel in | pix_valid  | pix_stall  | pix_word  (sbb_pkg::in_word_t)
//  blur out | blur_valid | blur_stall | blur_word (sbb_pkg::out_word_t)
//  config   | cfg_write  | -          | cfg_index, cfg_data
//
// a pixel left of column 2r is not stalled; one at column 2r or beyond goes
// through S_HACC to S_WR, and in a row of 2r or beyond on through S_VRD to S_OUT
// to yield a word; the work is set by the n-step horizontal sum over the window
// (n = 2r+1), the bit-serial dividers and the n reads of the line store's single
// read port; pix_stall is high while a pixel is being worked on
// one finished word waits in the output register; the next pixel is accepted
// meanwhile, and its result waits until that word is taken
// reset clears control and the pixel window; the line store is not cleared
module separable_box_blur #(
    parameter int MAX_WIDTH  = sbb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sbb_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = sbb_pkg::DEF_MAX_RADIUS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  sbb_pkg::in_word_t     pix_word,
    output logic                  blur_valid,
    input  logic                  blur_stall,
    output sbb_pkg::out_word_t    blur_word,
    input  logic                  cfg_write,
    input  logic [sbb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sbb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sbb_pkg::*;

    localparam int WIN   = 2 * MAX_RADIUS + 1;
    localparam int NW    = $clog2(WIN + 1);
    localparam int SW    = (WIN > 1) ? $clog2(WIN) : 1;
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);
    localparam int SUM_W = $clog2(WIN * 255 + 1);
    localparam int NUM_W = (SUM_W + 2 > RW) ? SUM_W + 2 : RW;
    localparam int DEN_W = $clog2(2 * WIN + 1);
    localparam int DEPTH = WIN * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int LANES = 5;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_HACC    = 4'd1;
    localparam logic [3:0] S_HDIV_GO = 4'd2;
    localparam logic [3:0] S_HDIV    = 4'd3;
    localparam logic [3:0] S_WR      = 4'd4;
    localparam logic [3:0] S_VRD     = 4'd5;
    localparam logic [3:0] S_VDIV_GO = 4'd6;
    localparam logic [3:0] S_VDIV    = 4'd7;
    localparam logic [3:0] S_OUT     = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [11:0] width_cfg_reg;
    logic [11:0] height_cfg_reg;
    logic [3:0]  radius_cfg_reg;

    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [31:0]   win_reg [WIN];

    logic [NW-1:0]    n_reg;
    logic [NW-1:0]    k_reg;
    logic [SW-1:0]    slot_reg;
    logic [SW-1:0]    rem_reg;
    logic [CW-1:0]    cc_reg;
    logic [RW-1:0]    orow_reg;
    logic             emit_reg;
    logic             fend_reg;
    logic             pend_reg;
    logic [SUM_W-1:0] sum_reg [4];
    logic [31:0]      hbar_reg;

    logic      out_valid_reg;
    out_word_t out_word_reg;

    logic [31:0] w32, h32, r32;
    logic [CW-1:0] w_cl;
    logic [RW-1:0] h_cl;
    logic [NW-1:0] rad_cl;
    logic [NW-1:0] n_cl;
    logic [CW:0]   c0;
    logic [RW:0]   r0;
    logic [CW:0]   c1;
    logic [RW:0]   r1;
    logic          accept;
    logic          out_take;

    logic             dv_start;
    logic [NUM_W-1:0] dv_num  [LANES];
    logic [DEN_W-1:0] dv_den  [LANES];
    logic             dv_busy [LANES];
    logic [NUM_W-1:0] dv_quo  [LANES];
    logic [DEN_W-1:0] dv_rem  [LANES];

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   mem_rdata;

    assign accept   = pix_valid && !pix_stall;
    assign out_take = out_valid_reg && !blur_stall;
    assign pix_stall = (state_reg != S_IDLE);

    always_comb
    begin
        w32 = 32'(width_cfg_reg);
        h32 = 32'(height_cfg_reg);
        r32 = 32'(radius_cfg_reg);
        if (w32 < 32'd1) w32 = 32'd1;
        if (w32 > 32'(MAX_WIDTH)) w32 = 32'(MAX_WIDTH);
        if (h32 < 32'd1) h32 = 32'd1;
        if (h32 > 32'(MAX_HEIGHT)) h32 = 32'(MAX_HEIGHT);
        if (r32 > 32'(MAX_RADIUS)) r32 = 32'(MAX_RADIUS);
        w_cl   = CW'(w32);
        h_cl   = RW'(h32);
        rad_cl = NW'(r32);
        n_cl   = NW'(2 * r32 + 32'd1);
    end

    // position of the incoming pixel, then of the one after it
    always_comb
    begin
        c0 = pix_word.frame_start ? '0 : {1'b0, col_reg};
        r0 = pix_word.frame_start ? '0 : {1'b0, row_reg};
        if (c0 >= {1'b0, w_cl})
        begin
            c0 = '0;
            r0 = r0 + 1'b1;
        end
        if (r0 >= {1'b0, h_cl})
        begin
            r0 = '0;
        end
        c1 = c0 + 1'b1;
        r1 = r0;
        if (c1 >= {1'b0, w_cl})
        begin
            c1 = '0;
            r1 = r0 + 1'b1;
            if (r1 >= {1'b0, h_cl})
            begin
                r1 = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= RST_IMAGE_WIDTH;
            height_cfg_reg <= RST_IMAGE_HEIGHT;
            radius_cfg_reg <= RST_BLUR_RADIUS;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_data[11:0];
                REG_IMAGE_HEIGHT: height_cfg_reg <= cfg_data[11:0];
                REG_BLUR_RADIUS:  radius_cfg_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (c0 >= (CW+1)'(2 * rad_cl)))
                begin
                    state_next = S_HACC;
                end
            end
            S_HACC:
            begin
                if (k_reg == n_reg - 1'b1)
                begin
                    state_next = S_HDIV_GO;
                end
            end
            S_HDIV_GO: state_next = S_HDIV;
            S_HDIV:
            begin
                if (!dv_busy[0])
                begin
                    state_next = S_WR;
                end
            end
            S_WR: state_next = emit_reg ? S_VRD : S_IDLE;
            S_VRD:
            begin
                if ((k_reg == n_reg) && !pend_reg)
                begin
                    state_next = S_VDIV_GO;
                end
            end
            S_VDIV_GO: state_next = S_VDIV;
            S_VDIV:
            begin
                if (!dv_busy[0])
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < WIN; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                col_reg <= CW'(c1);
                row_reg <= RW'(r1);
                for (int i = WIN - 1; i > 0; i--)
                begin
                    win_reg[i] <= (c0 == '0) ? '0 : win_reg[i-1];
                end
                win_reg[0] <= {pix_word.in_alpha, pix_word.in_red,
                               pix_word.in_green, pix_word.in_blue};
            end
            if (state_reg == S_OUT && (!out_valid_reg || out_take))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers of the sequencer
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    n_reg    <= n_cl;
                    k_reg    <= '0;
                    cc_reg   <= CW'(c0 - (CW+1)'(rad_cl));
                    orow_reg <= RW'(r0 - (RW+1)'(rad_cl));
                    emit_reg <= (r0 >= (RW+1)'(2 * rad_cl));
                    fend_reg <= (c0 == (CW+1)'(w_cl - 1'b1)) &&
                                (r0 == (RW+1)'(h_cl - 1'b1));
                    for (int ch = 0; ch < 4; ch++)
                    begin
                        sum_reg[ch] <= '0;
                    end
                end
            end
            S_HACC:
            begin
                for (int ch = 0; ch < 4; ch++)
                begin
                    sum_reg[ch] <= sum_reg[ch] +
                                   SUM_W'(win_reg[k_reg[SW-1:0]][8*ch +: 8]);
                end
                k_reg <= k_reg + 1'b1;
            end
            S_HDIV:
            begin
                if (!dv_busy[0])
                begin
                    for (int ch = 0; ch < 4; ch++)
                    begin
                        hbar_reg[8*ch +: 8] <= dv_quo[ch][7:0];
                    end
                    rem_reg <= dv_rem[4][SW-1:0];
                end
            end
            S_WR:
            begin
                k_reg    <= '0;
                slot_reg <= rem_reg;
                pend_reg <= 1'b0;
                for (int ch = 0; ch < 4; ch++)
                begin
                    sum_reg[ch] <= '0;
                end
            end
            S_VRD:
            begin
                if (pend_reg)
                begin
                    for (int ch = 0; ch < 4; ch++)
                    begin
                        sum_reg[ch] <= sum_reg[ch] + SUM_W'(mem_rdata[8*ch +: 8]);
                    end
                end
                if (k_reg != n_reg)
                begin
                    k_reg    <= k_reg + 1'b1;
                    pend_reg <= 1'b1;
                    slot_reg <= (slot_reg == '0) ? SW'(n_reg - 1'b1) : slot_reg - 1'b1;
                end
                else
                begin
                    pend_reg <= 1'b0;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_word_reg.out_col   <= 11'(cc_reg);
                    out_word_reg.out_row   <= 11'(orow_reg);
                    out_word_reg.out_alpha <= dv_quo[3][7:0];
                    out_word_reg.out_red   <= dv_quo[2][7:0];
                    out_word_reg.out_green <= dv_quo[1][7:0];
                    out_word_reg.out_blue  <= dv_quo[0][7:0];
                    out_word_reg.frame_end <= fend_reg;
                end
            end
            default: ;
        endcase
    end

    // four channel lanes share the rounding divide, the fifth finds row mod n
    assign dv_start = (state_reg == S_HDIV_GO) || (state_reg == S_VDIV_GO);

    always_comb
    begin
        for (int ch = 0; ch < 4; ch++)
        begin
            dv_num[ch] = NUM_W'({sum_reg[ch], 1'b0}) + NUM_W'(n_reg);
            dv_den[ch] = DEN_W'({n_reg, 1'b0});
        end
        // row = orow + r, truncated to RW bits
        dv_num[4] = NUM_W'(RW'(orow_reg + RW'(n_reg >> 1)));
        dv_den[4] = DEN_W'(n_reg);
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        sbb_div #(
            .NUM_W(NUM_W),
            .DEN_W(DEN_W)
        ) u_div (
            .clk   (clk),
            .rst_n (rst_n),
            .start (dv_start),
            .num   (dv_num[g]),
            .den   (dv_den[g]),
            .busy  (dv_busy[g]),
            .quo   (dv_quo[g]),
            .rem   (dv_rem[g])
        );
    end

    assign mem_we    = (state_reg == S_WR);
    assign mem_waddr = AW'(AW'(rem_reg) * AW'(MAX_WIDTH) + AW'(cc_reg));
    assign mem_raddr = AW'(AW'(slot_reg) * AW'(MAX_WIDTH) + AW'(cc_reg));

    sbb_line_mem #(
        .DEPTH(DEPTH),
        .AW   (AW),
        .DW   (32)
    ) u_line_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (hbar_reg),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign blur_valid = out_valid_reg;
    assign blur_word  = out_word_reg;

endmodule

>>> design/sbb_checker.sv
// port-level checks for the separable box blur, bound to the top level
// depends on sbb_pkg and separable_box_blur
module sbb_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               pix_valid,
    input logic               pix_stall,
    input logic               blur_valid,
    input logic               blur_stall,
    input sbb_pkg::out_word_t blur_word
);
    import sbb_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        blur_valid && blur_stall |=> blur_valid && $stable(blur_word))
        else $error("stalled output word changed or dropped");

    a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(blur_valid) |-> $past(pix_stall))
        else $error("output word appeared without a busy cycle before it");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_stall |=> !$rose(blur_valid))
        else $error("output word appeared right after a pixel was taken");

endmodule

bind separable_box_blur sbb_checker u_sbb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .blur_valid (blur_valid),
    .blur_stall (blur_stall),
    .blur_word  (blur_word)
);
